FILE: hw/rtl/salcd_pkg.sv
// Shared types and constants of the cache tag directory.
`timescale 1ns / 1ps
`default_nettype none
package salcd_pkg;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_BAD_SIZE   = 2'd1;
    localparam logic [1:0] STATUS_MISALIGNED = 2'd2;

    localparam logic [1:0] REG_LOG2_SETS       = 2'd0;
    localparam logic [1:0] REG_WAYS            = 2'd1;
    localparam logic [1:0] REG_LOG2_LINE_BYTES = 2'd2;

    localparam logic [3:0] MAX_LOG2_LINE_BYTES = 4'd12;

    typedef struct packed {
        logic        mode;
        logic [3:0]  access_size;
        logic [31:0] address;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        hit;
        logic [1:0]  mem_refs;
        logic [31:0] line_tag;
        logic [12:0] set_index;
        logic [11:0] line_offset;
        logic [31:0] access_number;
    } rsp_t;

endpackage
`default_nettype wire

FILE: hw/rtl/set_assoc_lru_cache_directory_unit.sv
// Top level of the set-associative write-back LRU cache tag directory.
// Usage:
//   The request channel (req_valid, req_stall, req) carries one access per beat:
//   mode, access size and byte address. The response channel (rsp_valid,
//   rsp_stall, rsp) returns one result beat per request: status, hit, memory
//   reference count, the address split into tag, set and offset, and the
//   running access count.
//   The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) sets
//   log2 of the set count, the way count and log2 of the line size. Write it
//   only while the directory is idle.
//   Each set lives in one row of a synchronous memory. The row is read at the
//   accepting edge, and the result is registered with the write-back of the
//   row once the output register is free.
//   A new request is taken only once the read-modify-write of the set row for
//   the last one has finished.
//   After reset the directory clears every row, one per cycle, and takes no
//   request meanwhile.
//   When the receiver stalls, a finished result is held in the output register;
//   one further request may be accepted and waits in its lookup until the
//   output register is free.
`timescale 1ns / 1ps
`default_nettype none
module set_assoc_lru_cache_directory_unit
    import salcd_pkg::*;
#(
    parameter int MAX_SET_COUNT = 8192,
    parameter int MAX_WAY_COUNT = 8,
    parameter int ADDR_BITS     = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_stall,
    input  wire req_t        req,
    output logic             rsp_valid,
    input  wire logic        rsp_stall,
    output rsp_t             rsp,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [3:0]  cfg_data
);

    localparam int IDX_W    = (MAX_SET_COUNT > 1) ? $clog2(MAX_SET_COUNT) : 1;
    localparam int SET_LOG  = $clog2(MAX_SET_COUNT + 1) - 1;
    localparam int AGE_W    = (MAX_WAY_COUNT > 1) ? $clog2(MAX_WAY_COUNT) : 1;
    localparam logic [31:0] ADDR_MASK =
        (ADDR_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << ADDR_BITS) - 64'd1);

    typedef struct packed {
        logic [MAX_WAY_COUNT-1:0]                  valid;
        logic [MAX_WAY_COUNT-1:0]                  dirty;
        logic [MAX_WAY_COUNT-1:0][31:0]            tag;
        logic [MAX_WAY_COUNT-1:0][AGE_W-1:0]       age;
    } row_t;

    row_t mem [MAX_SET_COUNT];

    state_t state_reg, state_next;
    logic [3:0] log2_sets_reg, ways_reg, log2_line_bytes_reg;
    logic [IDX_W-1:0] clr_reg, clr_next;
    logic [31:0] count_reg, count_next;
    logic rsp_valid_reg, rsp_valid_next;
    rsp_t rsp_reg, rsp_next;

    logic [1:0]       pend_status_reg, pend_status_next;
    logic             pend_mode_reg, pend_mode_next;
    logic [31:0]      pend_tag_reg, pend_tag_next;
    logic [12:0]      pend_set_reg, pend_set_next;
    logic [11:0]      pend_off_reg, pend_off_next;
    logic [IDX_W-1:0] pend_idx_reg, pend_idx_next;

    row_t rd_row;
    row_t wr_row;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;

    logic accept;
    logic finish;

    // Address split
    logic [4:0]  sbits;
    logic [3:0]  obits;
    logic [31:0] addr_m;
    logic [31:0] set_full;
    logic [5:0]  tag_shift;
    logic [3:0]  size_m1;

    // Lookup
    logic [4:0]             nways;
    logic                   found;
    logic [AGE_W-1:0]       hit_way;
    logic [AGE_W-1:0]       vic_way;
    logic                   vic_seen;
    logic [AGE_W-1:0]       way;
    logic [AGE_W-1:0]       old_age;
    row_t                   upd_row;
    logic [1:0]             refs;

    assign cfg_ready = 1'b1;
    assign accept    = req_valid && !req_stall;
    assign finish    = (state_reg == ST_LOOKUP) && (!rsp_valid_reg || !rsp_stall);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        sbits = ({1'b0, log2_sets_reg} > 5'(SET_LOG)) ? 5'(SET_LOG) : {1'b0, log2_sets_reg};
        obits = (log2_line_bytes_reg > MAX_LOG2_LINE_BYTES) ? MAX_LOG2_LINE_BYTES
                                                            : log2_line_bytes_reg;
        nways = (ways_reg == 4'd0) ? 5'd1 : {1'b0, ways_reg};
        if (nways > 5'(MAX_WAY_COUNT))
        begin
            nways = 5'(MAX_WAY_COUNT);
        end
        addr_m    = req.address & ADDR_MASK;
        tag_shift = 6'(obits) + 6'(sbits);
        set_full  = (addr_m >> obits) & ~(32'hFFFF_FFFF << sbits);
        size_m1   = req.access_size - 4'd1;

        pend_mode_next = req.mode;
        pend_tag_next  = addr_m >> tag_shift;
        pend_set_next  = 13'(set_full);
        pend_idx_next  = IDX_W'(set_full);
        pend_off_next  = addr_m[11:0] & ~(12'hFFF << obits);
        if (!(req.access_size == 4'd1 || req.access_size == 4'd2 ||
              req.access_size == 4'd4 || req.access_size == 4'd8))
        begin
            pend_status_next = STATUS_BAD_SIZE;
        end
        else if ((req.address[2:0] & size_m1[2:0]) != 3'd0)
        begin
            pend_status_next = STATUS_MISALIGNED;
        end
        else
        begin
            pend_status_next = STATUS_OK;
        end
    end

    always_comb
    begin
        found    = 1'b0;
        hit_way  = '0;
        vic_way  = '0;
        vic_seen = 1'b0;
        for (int i = 0; i < MAX_WAY_COUNT; i++)
        begin
            if (5'(i) < nways)
            begin
                if (rd_row.valid[i] && rd_row.tag[i] == pend_tag_reg)
                begin
                    found   = 1'b1;
                    hit_way = AGE_W'(i);
                end
                if (!vic_seen && rd_row.age[i] == '0)
                begin
                    vic_seen = 1'b1;
                    vic_way  = AGE_W'(i);
                end
            end
        end
        way     = found ? hit_way : vic_way;
        old_age = found ? rd_row.age[hit_way] : '0;
        upd_row = rd_row;
        for (int i = 0; i < MAX_WAY_COUNT; i++)
        begin
            if (5'(i) < nways && rd_row.age[i] > old_age)
            begin
                upd_row.age[i] = rd_row.age[i] - AGE_W'(1);
            end
        end
        upd_row.age[way] = AGE_W'(nways - 5'd1);
        if (found)
        begin
            refs = 2'd0;
            if (pend_mode_reg)
            begin
                upd_row.dirty[way] = 1'b1;
            end
        end
        else
        begin
            refs = (rd_row.valid[way] && rd_row.dirty[way]) ? 2'd2 : 2'd1;
            upd_row.valid[way] = 1'b1;
            upd_row.dirty[way] = pend_mode_reg;
            upd_row.tag[way]   = pend_tag_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == IDX_W'(MAX_SET_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        req_stall      = (state_reg != ST_IDLE);
        clr_next       = clr_reg;
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        wr_en          = 1'b0;
        wr_addr        = pend_idx_reg;
        wr_row         = upd_row;
        case (state_reg)
            ST_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                wr_row   = '0;
                clr_next = clr_reg + IDX_W'(1);
            end
            ST_LOOKUP:
            begin
                if (finish)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = '0;
                    rsp_next.status = pend_status_reg;
                    if (pend_status_reg == STATUS_OK)
                    begin
                        wr_en                  = 1'b1;
                        count_next             = count_reg + 32'd1;
                        rsp_next.hit           = found;
                        rsp_next.mem_refs      = refs;
                        rsp_next.line_tag      = pend_tag_reg;
                        rsp_next.set_index     = pend_set_reg;
                        rsp_next.line_offset   = pend_off_reg;
                        rsp_next.access_number = count_reg + 32'd1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_row;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_row <= mem[pend_idx_next];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_status_reg <= pend_status_next;
            pend_mode_reg   <= pend_mode_next;
            pend_tag_reg    <= pend_tag_next;
            pend_set_reg    <= pend_set_next;
            pend_off_reg    <= pend_off_next;
            pend_idx_reg    <= pend_idx_next;
        end
        rsp_reg <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_CLEAR;
            clr_reg             <= '0;
            count_reg           <= '0;
            rsp_valid_reg       <= 1'b0;
            log2_sets_reg       <= 4'd0;
            ways_reg            <= 4'd1;
            log2_line_bytes_reg <= 4'd4;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_LOG2_SETS:       log2_sets_reg       <= cfg_data;
                    REG_WAYS:            ways_reg            <= cfg_data;
                    REG_LOG2_LINE_BYTES: log2_line_bytes_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

endmodule
`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for the set-associative LRU cache tag directory.
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import salcd_pkg::*;

    localparam int SETS = 8192;
    localparam int NWAY = 8;
    localparam int CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;
    logic cfg_valid;
    logic cfg_ready;
    logic [1:0] cfg_index;
    logic [3:0] cfg_data;

    set_assoc_lru_cache_directory_unit dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    logic        dir_valid [SETS*NWAY];
    logic        dir_dirty [SETS*NWAY];
    logic [31:0] dir_tag [SETS*NWAY];
    logic [2:0]  dir_age [SETS*NWAY];
    logic [31:0] access_total;
    logic [3:0]  geo_sets;
    logic [3:0]  geo_ways;
    logic [3:0]  geo_line;

    rsp_t pending_rsp[$];
    int   mismatches;
    int   cycles;
    int   send_idle_pct;
    int   recv_idle_pct;
    bit   hold_off;

    typedef struct {
        req_t       beat;
        bit         known;
        logic [1:0] status;
    } vector_t;

    vector_t vectors[$];

    function automatic rsp_t lookup_access(req_t a);
        rsp_t r;
        int sb, ob, nw, b, w;
        logic [31:0] off, idx, tg;
        bit found;
        int aged;
        r = '0;
        if (!(a.access_size inside {4'd1, 4'd2, 4'd4, 4'd8})) begin
            r.status = STATUS_BAD_SIZE;
            return r;
        end
        if ((a.address & (32'(a.access_size) - 32'd1)) != 32'd0) begin
            r.status = STATUS_MISALIGNED;
            return r;
        end
        sb = (geo_sets > 13) ? 13 : geo_sets;
        ob = (geo_line > 12) ? 12 : geo_line;
        nw = (geo_ways == 0) ? 1 : ((geo_ways > NWAY) ? NWAY : geo_ways);
        off = a.address & ((32'd1 << ob) - 32'd1);
        idx = (a.address >> ob) & ((32'd1 << sb) - 32'd1);
        tg = 32'(64'(a.address) >> (ob + sb));
        b = idx * NWAY;
        access_total = access_total + 32'd1;
        found = 0;
        w = 0;
        for (int i = 0; i < nw; i++)
            if (dir_valid[b+i] && dir_tag[b+i] == tg) begin
                found = 1;
                w = i;
            end
        if (found) begin
            if (a.mode) dir_dirty[b+w] = 1;
            aged = dir_age[b+w];
            for (int i = 0; i < nw; i++)
                if (dir_age[b+i] > aged) dir_age[b+i] = dir_age[b+i] - 3'd1;
            dir_age[b+w] = 3'(nw - 1);
        end else begin
            w = 0;
            for (int i = nw - 1; i >= 0; i--)
                if (dir_age[b+i] == 0) w = i;
            r.mem_refs = (dir_valid[b+w] && dir_dirty[b+w]) ? 2'd2 : 2'd1;
            dir_valid[b+w] = 1;
            dir_dirty[b+w] = a.mode;
            dir_tag[b+w] = tg;
            for (int i = 0; i < nw; i++)
                if (dir_age[b+i] > 0) dir_age[b+i] = dir_age[b+i] - 3'd1;
            dir_age[b+w] = 3'(nw - 1);
        end
        r.status = STATUS_OK;
        r.hit = found;
        r.line_tag = tg;
        r.set_index = idx[12:0];
        r.line_offset = off[11:0];
        r.access_number = access_total;
        return r;
    endfunction

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        rsp_stall = 0;
        forever begin
            @(posedge clk);
            if (hold_off) rsp_stall <= 1;
            else rsp_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk) begin
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall) begin
            if (pending_rsp.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result beat %p", rsp);
            end else begin
                want = pending_rsp.pop_front();
                if (rsp !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected %p, got %p", want, rsp);
                end
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [3:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == REG_LOG2_SETS) geo_sets = val;
        else if (idx == REG_WAYS) geo_ways = val;
        else geo_line = val;
    endtask

    task automatic set_geometry(logic [3:0] s, logic [3:0] w, logic [3:0] l);
        req_valid <= 0;
        while (pending_rsp.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
        write_reg(REG_LOG2_SETS, s);
        write_reg(REG_WAYS, w);
        write_reg(REG_LOG2_LINE_BYTES, l);
        cfg_valid <= 0;
    endtask

    task automatic send_access(req_t a, bit known, logic [1:0] st);
        rsp_t want;
        while ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 0;
            @(posedge clk);
        end
        req_valid <= 1;
        req <= a;
        do @(posedge clk); while (req_stall);
        want = lookup_access(a);
        if (known) want.status = st;
        pending_rsp = {pending_rsp, want};
    endtask

    function automatic req_t random_access(int tag_bits);
        req_t a;
        int sz;
        a.mode = 1'($urandom_range(1));
        sz = $urandom_range(3);
        a.access_size = 4'd1 << sz;
        a.address = 32'({4'($urandom_range((1 << tag_bits) - 1)), 8'($urandom_range(255)),
                         4'h0})
                    | (32'($urandom_range(7)) & ~((32'd1 << sz) - 32'd1));
        a.address = (a.address << 4) ^ ($urandom_range(1) ? 32'h0 : $urandom() & 32'hFFFF0000);
        a.address = a.address & ~(32'(a.access_size) - 32'd1);
        if ($urandom_range(99) < 8) begin
            a.access_size = 4'($urandom_range(15));
            a.address = $urandom();
        end
        return a;
    endfunction

    task automatic add_vector(logic m, logic [3:0] s, logic [31:0] ad, bit k, logic [1:0] st);
        vector_t v;
        v.beat = '{mode: m, access_size: s, address: ad};
        v.known = k;
        v.status = st;
        vectors = {vectors, v};
    endtask

    initial begin
        mismatches = 0;
        hold_off = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rst_n = 0;
        req_valid = 0;
        req = '0;
        cfg_valid = 0;
        cfg_index = REG_LOG2_SETS;
        cfg_data = '0;
        for (int i = 0; i < SETS * NWAY; i++) begin
            dir_valid[i] = 0;
            dir_dirty[i] = 0;
            dir_tag[i] = '0;
            dir_age[i] = '0;
        end
        access_total = 0;
        geo_sets = 0;
        geo_ways = 1;
        geo_line = 4;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        add_vector(0, 4'd1, 32'h0000_0000, 0, STATUS_OK);
        add_vector(0, 4'd1, 32'h0000_0000, 0, STATUS_OK);
        add_vector(1, 4'd8, 32'hFFFF_FFF8, 0, STATUS_OK);
        add_vector(0, 4'd8, 32'hFFFF_FFF8, 0, STATUS_OK);
        add_vector(1, 4'd2, 32'h0000_1002, 0, STATUS_OK);
        add_vector(0, 4'd4, 32'h0000_0004, 0, STATUS_OK);
        add_vector(1, 4'd0, 32'h0000_0000, 1, STATUS_BAD_SIZE);
        add_vector(0, 4'd3, 32'h0000_0000, 1, STATUS_BAD_SIZE);
        add_vector(1, 4'd15, 32'hFFFF_FFFF, 1, STATUS_BAD_SIZE);
        add_vector(0, 4'd2, 32'h0000_0001, 1, STATUS_MISALIGNED);
        add_vector(1, 4'd4, 32'h0000_0002, 1, STATUS_MISALIGNED);
        add_vector(0, 4'd8, 32'hFFFF_FFFC, 1, STATUS_MISALIGNED);
        add_vector(1, 4'd8, 32'h5555_AAA8, 0, STATUS_OK);
        add_vector(0, 4'd1, 32'hAAAA_5557, 0, STATUS_OK);

        send_idle_pct = 23;
        recv_idle_pct = 53;
        foreach (vectors[i]) send_access(vectors[i].beat, vectors[i].known, vectors[i].status);

        set_geometry(4'd15, 4'd0, 4'd15);
        for (int i = 0; i < 40; i++) send_access(random_access(2), 0, STATUS_OK);

        set_geometry(4'd2, 4'd15, 4'd0);
        for (int i = 0; i < 150; i++) send_access(random_access(3), 0, STATUS_OK);

        send_idle_pct = 53;
        recv_idle_pct = 23;
        set_geometry(4'd0, 4'd4, 4'd12);
        for (int i = 0; i < 150; i++) send_access(random_access(2), 0, STATUS_OK);

        set_geometry(4'd13, 4'd8, 4'd3);
        hold_off = 1;
        fork
            begin
                repeat (60) @(posedge clk);
                hold_off = 0;
            end
            for (int i = 0; i < 150; i++) send_access(random_access(4), 0, STATUS_OK);
        join

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_geometry(4'd1, 4'd2, 4'd5);
        for (int i = 0; i < 250; i++) send_access(random_access(3), 0, STATUS_OK);

        req_valid <= 0;
        while (pending_rsp.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0 && pending_rsp.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
`default_nettype wire

FILE: filelist.f
hw/rtl/salcd_pkg.sv
hw/rtl/set_assoc_lru_cache_directory_unit.sv
tb/tb.sv
